// File: rtl/mrfr_pkg.sv
// Shared types and constants for the request frame receiver.
// Depends on nothing; used by every module under rtl/.
package mrfr_pkg;

    localparam int INDEX_BITS = 8;
    localparam int BYTE_BITS  = 8;
    localparam int DATA_BITS  = 9;

    localparam logic [INDEX_BITS-1:0] INDEX_ZERO = '0;
    localparam logic [INDEX_BITS-1:0] INDEX_ONE  = INDEX_BITS'(1);

    localparam logic [BYTE_BITS-1:0] FN_READ    = 8'h04;
    localparam logic [BYTE_BITS-1:0] FN_WRITE   = 8'h10;
    localparam logic [BYTE_BITS-1:0] ABORT_MARK = 8'hEE;

    localparam logic [DATA_BITS-1:0] DATA_ONE = DATA_BITS'(1);

    // Frame parse position, one-hot
    typedef enum logic [9:0] {
        ST_STATION  = 10'b00_0000_0001,
        ST_FUNCTION = 10'b00_0000_0010,
        ST_ADDR_HI  = 10'b00_0000_0100,
        ST_ADDR_LO  = 10'b00_0000_1000,
        ST_LEN_HI   = 10'b00_0001_0000,
        ST_LEN_LO   = 10'b00_0010_0000,
        ST_BYTE_CNT = 10'b00_0100_0000,
        ST_CRC_LO   = 10'b00_1000_0000,
        ST_CRC_HI   = 10'b01_0000_0000,
        ST_DATA     = 10'b10_0000_0000
    } step_t;

    // One result transaction
    typedef struct packed {
        logic                 store_valid;
        logic [BYTE_BITS-1:0] store_index;
        logic [BYTE_BITS-1:0] store_byte;
        logic                 function_accepted;
        logic                 frame_aborted;
        logic                 frame_done;
    } result_t;

endpackage

// File: rtl/mrfr_parser.sv
// Frame parser: parse state registers and the single-pass result logic.
// Depends on mrfr_pkg.
module mrfr_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [7:0]                rx_byte,
    input  logic                      line_error,
    input  logic                      transmit_busy,
    output mrfr_pkg::result_t         result
);
    import mrfr_pkg::*;

    step_t                  step_reg,     step_next;
    logic [INDEX_BITS-1:0]  windex_reg,   windex_next;
    logic                   is_write_reg, is_write_next;
    logic [BYTE_BITS-1:0]   len_lo_reg,   len_lo_next;
    logic [DATA_BITS-1:0]   remain_reg,   remain_next;

    logic                   keep;
    logic [INDEX_BITS-1:0]  windex_inc;

    assign windex_inc = windex_reg + INDEX_ONE;

    always_comb
    begin
        step_next     = step_reg;
        windex_next   = windex_reg;
        is_write_next = is_write_reg;
        len_lo_next   = len_lo_reg;
        remain_next   = remain_reg;
        keep          = 1'b0;
        result        = '0;

        if (!(line_error || transmit_busy))
        begin
            case (step_reg)
                ST_STATION:
                begin
                    keep      = 1'b1;
                    step_next = ST_FUNCTION;
                end
                ST_FUNCTION:
                begin
                    if (rx_byte inside {FN_READ, FN_WRITE})
                    begin
                        keep                     = 1'b1;
                        result.function_accepted = 1'b1;
                        is_write_next            = (rx_byte == FN_WRITE);
                        step_next                = ST_ADDR_HI;
                    end
                end
                ST_ADDR_HI:
                begin
                    keep      = 1'b1;
                    step_next = ST_ADDR_LO;
                end
                ST_ADDR_LO:
                begin
                    if (rx_byte == ABORT_MARK)
                    begin
                        result.frame_aborted = 1'b1;
                        step_next            = ST_STATION;
                        windex_next          = INDEX_ZERO;
                    end
                    else
                    begin
                        keep      = 1'b1;
                        step_next = ST_LEN_HI;
                    end
                end
                ST_LEN_HI:
                begin
                    keep      = 1'b1;
                    step_next = ST_LEN_LO;
                end
                ST_LEN_LO:
                begin
                    keep        = 1'b1;
                    len_lo_next = rx_byte;
                    step_next   = is_write_reg ? ST_BYTE_CNT : ST_CRC_LO;
                end
                ST_BYTE_CNT:
                begin
                    keep = 1'b1;
                    if (is_write_reg)
                    begin
                        remain_next = {len_lo_reg, 1'b0};
                        step_next   = ST_DATA;
                    end
                    else
                    begin
                        remain_next = '0;
                        step_next   = ST_CRC_LO;
                    end
                end
                ST_CRC_LO:
                begin
                    keep      = 1'b1;
                    step_next = ST_CRC_HI;
                end
                ST_CRC_HI:
                begin
                    result.store_valid = 1'b1;
                    result.store_index = windex_reg[BYTE_BITS-1:0];
                    result.store_byte  = rx_byte;
                    result.frame_done  = 1'b1;
                    windex_next        = INDEX_ZERO;
                    step_next          = ST_STATION;
                end
                ST_DATA:
                begin
                    keep = 1'b1;
                    if (remain_reg <= DATA_ONE)
                        step_next = ST_CRC_LO;
                    else
                        remain_next = remain_reg - DATA_ONE;
                end
                default:
                begin
                    windex_next = INDEX_ZERO;
                    step_next   = ST_STATION;
                end
            endcase

            if (keep)
            begin
                result.store_valid = 1'b1;
                result.store_index = windex_reg[BYTE_BITS-1:0];
                result.store_byte  = rx_byte;
                windex_next        = windex_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= ST_STATION;
            windex_reg   <= INDEX_ZERO;
            is_write_reg <= 1'b0;
            len_lo_reg   <= '0;
            remain_reg   <= '0;
        end
        else if (accept)
        begin
            step_reg     <= step_next;
            windex_reg   <= windex_next;
            is_write_reg <= is_write_next;
            len_lo_reg   <= len_lo_next;
            remain_reg   <= remain_next;
        end
    end

    // Frame end or abort rewinds the buffer index
    a_index_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (result.frame_done || result.frame_aborted)
        |=> windex_reg == INDEX_ZERO)
        else $error("index not rewound after frame end/abort");

    // Dropped bytes leave the parse state alone
    a_drop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (line_error || transmit_busy)
        |=> $stable(step_reg) && $stable(windex_reg) && $stable(remain_reg))
        else $error("dropped byte changed parse state");

    // Data phase is only entered with a write request pending
    a_data_is_write: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == ST_DATA |-> is_write_reg)
        else $error("data phase without write request");

    // Every stored byte advances the index unless it closes the frame
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.store_valid && !result.frame_done
        |=> windex_reg == $past(windex_inc))
        else $error("index did not advance on store");

endmodule

// File: rtl/mrfr_out_reg.sv
// Result register between the parser and the output channel.
// Depends on mrfr_pkg.
module mrfr_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_valid,
    output logic              load_ready,
    input  mrfr_pkg::result_t load_result,
    output logic              out_valid,
    input  logic              out_ready,
    output mrfr_pkg::result_t out_result
);
    import mrfr_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // Slot frees up in the same cycle the held result is taken
    assign load_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load_ready)
            valid_reg <= load_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
            result_reg <= load_result;
    end

    // A held result that is not taken is kept
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && result_reg == $past(result_reg))
        else $error("held result lost");

    // A loaded transaction always shows up at the output
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_valid && load_ready |=> valid_reg)
        else $error("loaded result not presented");

    // Empty-slot results never carry a store index without a store
    a_no_stray_index: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !result_reg.store_valid |-> result_reg.store_index == '0)
        else $error("store index without store");

endmodule

// File: rtl/modbus_request_frame_receiver.sv
// Top level of the request frame receiver: parser plus result register.
// Depends on mrfr_pkg, mrfr_parser and mrfr_out_reg.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | rx_byte, line_error, transmit_busy
//  out     | out_valid / out_ready| store_valid, store_index, store_byte,
//          |                      | function_accepted, frame_aborted, frame_done
//
// Every input transaction yields exactly one output transaction, presented in the cycle after it is accepted.
// One transaction per cycle while out_ready keeps up: the parse step, index and
// length registers update on each accepted transaction, and the result register is the
// only storage on the output side. in_ready drops only while a result is held and out_ready is low.
// rst_n (async, active low) returns the parser to waiting for the station byte
// with the buffer index at zero and empties the result register.
module modbus_request_frame_receiver (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       line_error,
    input  logic       transmit_busy,

    output logic       out_valid,
    input  logic       out_ready,
    output logic       store_valid,
    output logic [7:0] store_index,
    output logic [7:0] store_byte,
    output logic       function_accepted,
    output logic       frame_aborted,
    output logic       frame_done
);
    import mrfr_pkg::*;

    logic    accept;
    result_t parse_result;
    result_t out_result;

    // Parser state moves only on an accepted transaction
    assign accept = in_valid && in_ready;

    mrfr_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .rx_byte       (rx_byte),
        .line_error    (line_error),
        .transmit_busy (transmit_busy),
        .result        (parse_result)
    );

    mrfr_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (in_valid),
        .load_ready  (in_ready),
        .load_result (parse_result),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_result  (out_result)
    );

    assign store_valid       = out_result.store_valid;
    assign store_index       = out_result.store_index;
    assign store_byte        = out_result.store_byte;
    assign function_accepted = out_result.function_accepted;
    assign frame_aborted     = out_result.frame_aborted;
    assign frame_done        = out_result.frame_done;

    // At most one frame event per transaction
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({function_accepted, frame_aborted, frame_done}))
        else $error("multiple frame events in one result");

    // Frame end stores the last CRC byte; abort stores nothing
    a_event_store: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!frame_done || store_valid) && (!frame_aborted || !store_valid))
        else $error("frame event and store flag disagree");

    // A dropped byte produces an all-zero result
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (line_error || transmit_busy)
        |=> !store_valid && !function_accepted && !frame_aborted && !frame_done)
        else $error("dropped byte produced an event");

endmodule
